/* rtl/core/nft_pkg.sv */
package nft_pkg;

	localparam int RES_MAX   = 3;
	localparam int Q_DEPTH   = 8;
	localparam int Q_AW      = 3;
	localparam int TDATA_W   = 24;

	typedef enum logic [3:0] {
		KIND_NONE,
		KIND_EDIT,
		KIND_DYN,
		KIND_SFZ,
		KIND_MEZ,
		KIND_ARP,
		KIND_FING,
		KIND_ORN,
		KIND_MARK
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_MEZZO,
		ERR_UNKNOWN
	} err_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] start_col;
		logic [3:0] elem_len;
		logic [3:0] elem_number;
		err_t       error_code;
		logic       field_end;
	} res_t;

	typedef res_t [RES_MAX-1:0] res_vec_t;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	function automatic res_t mk_res(kind_t k, logic [3:0] s, logic [3:0] l,
			logic [3:0] num, err_t e, logic fe);
		res_t r;
		r.kind        = k;
		r.start_col   = s;
		r.elem_len    = l;
		r.elem_number = num;
		r.error_code  = e;
		r.field_end   = fe;
		return r;
	endfunction

	function automatic logic is_alnum(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h61 && c <= 8'h7a);
	endfunction

	// Kind of element that a character opens; KIND_NONE for characters that open
	// nothing (the space is checked separately).
	function automatic kind_t start_kind(logic [7:0] c);
		kind_t k;
		case (c)
			8'h26: k = KIND_EDIT;
			8'h70, 8'h66: k = KIND_DYN;
			8'h5a: k = KIND_SFZ;
			8'h6d: k = KIND_MEZ;
			8'h53: k = KIND_ARP;
			8'h31, 8'h32, 8'h33, 8'h34, 8'h35: k = KIND_FING;
			8'h74, 8'h72, 8'h6b, 8'h77, 8'h7e, 8'h63, 8'h4d, 8'h6a: k = KIND_ORN;
			8'h2d, 8'h28, 8'h29, 8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h7a, 8'h78, 8'h2a,
			8'h21, 8'h76, 8'h6e, 8'h6f, 8'h4f, 8'h51, 8'h41, 8'h56, 8'h3e, 8'h2e,
			8'h5f, 8'h3d, 8'h69, 8'h27, 8'h46, 8'h45, 8'h52, 8'h5e, 8'h2b:
				k = KIND_MARK;
			default: k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

/* rtl/core/nft_parser.sv */
module nft_parser #(
	parameter int FIELD_COLS = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        ch,
	input  logic              last,
	output nft_pkg::res_vec_t res,
	output logic [1:0]        res_n
);

	localparam logic [3:0] COLS = 4'(FIELD_COLS);

	nft_pkg::kind_t pend_kind_q;
	logic [3:0]     elem_start_q;
	logic [3:0]     elem_len_q;
	logic [3:0]     column_q;
	logic           finger_q;
	logic           skip_q;
	logic [3:0]     found_q;

	nft_pkg::kind_t pk;
	logic [3:0]     es, el, col, ef;
	logic           fs, sk;
	logic           used, flush;
	nft_pkg::kind_t sk_kind;

	always_comb begin
		pk    = pend_kind_q;
		es    = elem_start_q;
		el    = elem_len_q;
		col   = column_q;
		fs    = finger_q;
		sk    = skip_q;
		ef    = found_q;
		used  = 1'b0;
		flush = 1'b0;
		res   = '0;
		res_n = 2'd0;
		sk_kind = nft_pkg::start_kind(ch);

		if (!sk && col < COLS) begin
			case (pk)
				nft_pkg::KIND_EDIT: begin
					if (nft_pkg::is_alnum(ch)) begin
						pk = nft_pkg::KIND_NONE; es = '0; el = '0; fs = 1'b0;
						used = 1'b1;
					end else begin
						flush = 1'b1;
					end
				end
				nft_pkg::KIND_DYN: begin
					if (ch == nft_pkg::CH_P || ch == nft_pkg::CH_F) begin
						if (el != 4'hf) el = el + 4'd1;
						used = 1'b1;
					end else begin
						flush = 1'b1;
					end
				end
				nft_pkg::KIND_SFZ, nft_pkg::KIND_ARP: begin
					if ((pk == nft_pkg::KIND_SFZ && ch == nft_pkg::CH_P) ||
							(pk == nft_pkg::KIND_ARP && ch == nft_pkg::CH_D)) begin
						if (el != 4'hf) el = el + 4'd1;
						used = 1'b1;
					end
					flush = 1'b1;
				end
				nft_pkg::KIND_MEZ: begin
					if (ch == nft_pkg::CH_P || ch == nft_pkg::CH_F) begin
						if (el != 4'hf) el = el + 4'd1;
						flush = 1'b1;
					end else begin
						res[res_n] = nft_pkg::mk_res(nft_pkg::KIND_NONE, es, 4'd0, 4'd0,
							nft_pkg::ERR_MEZZO, 1'b0);
						res_n = res_n + 2'd1;
						pk = nft_pkg::KIND_NONE; es = '0; el = '0; fs = 1'b0;
						sk = 1'b1;
					end
					used = 1'b1;
				end
				nft_pkg::KIND_FING: begin
					if (fs) begin
						if (el != 4'hf) el = el + 4'd1;
						flush = 1'b1;
						used = 1'b1;
					end else if (ch == nft_pkg::CH_COLON) begin
						if (el != 4'hf) el = el + 4'd1;
						fs = 1'b1;
						used = 1'b1;
					end else begin
						flush = 1'b1;
					end
				end
				nft_pkg::KIND_ORN: begin
					if (ch == nft_pkg::CH_S || ch == nft_pkg::CH_F ||
							ch == nft_pkg::CH_H || ch == nft_pkg::CH_U) begin
						if (el != 4'hf) el = el + 4'd1;
						used = 1'b1;
					end else begin
						flush = 1'b1;
					end
				end
				default: begin
					pk = nft_pkg::KIND_NONE; es = '0; el = '0; fs = 1'b0;
				end
			endcase

			if (flush) begin
				if (pk != nft_pkg::KIND_NONE) begin
					if (ef != 4'hf) ef = ef + 4'd1;
					res[res_n] = nft_pkg::mk_res(pk, es, el, ef, nft_pkg::ERR_NONE, 1'b0);
					res_n = res_n + 2'd1;
				end
				pk = nft_pkg::KIND_NONE; es = '0; el = '0; fs = 1'b0;
			end

			if (!used) begin
				if (ch == nft_pkg::CH_SPACE) begin
					pk = pk;
				end else if (sk_kind == nft_pkg::KIND_NONE) begin
					res[res_n] = nft_pkg::mk_res(nft_pkg::KIND_NONE, col, 4'd0, 4'd0,
						nft_pkg::ERR_UNKNOWN, 1'b0);
					res_n = res_n + 2'd1;
					sk = 1'b1;
				end else if (sk_kind == nft_pkg::KIND_MARK) begin
					if (ef != 4'hf) ef = ef + 4'd1;
					res[res_n] = nft_pkg::mk_res(nft_pkg::KIND_MARK, col, 4'd1, ef,
						nft_pkg::ERR_NONE, 1'b0);
					res_n = res_n + 2'd1;
				end else begin
					pk = sk_kind; es = col; el = 4'd1; fs = 1'b0;
				end
			end
		end

		if (col < COLS) col = col + 4'd1;

		if (last) begin
			if (!sk) begin
				if (pk == nft_pkg::KIND_MEZ) begin
					res[res_n] = nft_pkg::mk_res(nft_pkg::KIND_NONE, es, 4'd0, 4'd0,
						nft_pkg::ERR_MEZZO, 1'b0);
					res_n = res_n + 2'd1;
				end else if (pk != nft_pkg::KIND_NONE) begin
					if (ef != 4'hf) ef = ef + 4'd1;
					res[res_n] = nft_pkg::mk_res(pk, es, el, ef, nft_pkg::ERR_NONE, 1'b0);
					res_n = res_n + 2'd1;
				end
			end
			res[res_n] = nft_pkg::mk_res(nft_pkg::KIND_NONE, 4'd0, 4'd0, ef,
				nft_pkg::ERR_NONE, 1'b1);
			res_n = res_n + 2'd1;
			pk  = nft_pkg::KIND_NONE;
			es  = '0;
			el  = '0;
			fs  = 1'b0;
			col = '0;
			sk  = 1'b0;
			ef  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_kind_q  <= nft_pkg::KIND_NONE;
			elem_start_q <= '0;
			elem_len_q   <= '0;
			column_q     <= '0;
			finger_q     <= 1'b0;
			skip_q       <= 1'b0;
			found_q      <= '0;
		end else if (fire) begin
			pend_kind_q  <= pk;
			elem_start_q <= es;
			elem_len_q   <= el;
			column_q     <= col;
			finger_q     <= fs;
			skip_q       <= sk;
			found_q      <= ef;
		end
	end

endmodule

/* rtl/core/nft_resq.sv */
module nft_resq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  nft_pkg::res_vec_t push_res,
	input  logic [1:0]        push_n,
	output logic              room,
	output logic              head_valid,
	output nft_pkg::res_t     head,
	input  logic              pop
);

	localparam int Q_CW = nft_pkg::Q_AW + 1;
	localparam logic [Q_CW-1:0] ROOM_MAX = Q_CW'(nft_pkg::Q_DEPTH - nft_pkg::RES_MAX);

	nft_pkg::res_t           mem [nft_pkg::Q_DEPTH];
	logic [nft_pkg::Q_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CW-1:0]          count_q;
	logic [1:0]               n_in;
	logic                     pop_ok;

	assign n_in       = push ? push_n : 2'd0;
	assign head_valid = (count_q != '0);
	assign pop_ok     = pop && head_valid;
	assign room       = (count_q <= ROOM_MAX);
	assign head       = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < nft_pkg::RES_MAX; i++) begin
			if (push && 2'(i) < push_n)
				mem[nft_pkg::Q_AW'(wr_ptr_q + nft_pkg::Q_AW'(i))] <= push_res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= nft_pkg::Q_AW'(wr_ptr_q + nft_pkg::Q_AW'(n_in));
			if (pop_ok) rd_ptr_q <= rd_ptr_q + nft_pkg::Q_AW'(1);
			count_q <= Q_CW'(count_q + Q_CW'(n_in) - Q_CW'(pop_ok));
		end
	end

endmodule

/* rtl/core/notation_field_tokenizer.sv */
// A character is registered in the input stage and its results in the result queue.
// Throughput: one character per cycle while results drain as fast as they are made;
// a character yields up to three results, sent one per cycle while m_tready is high
// from an eight-entry queue that must have room for three. Reset clears the tokenizer
// state, the input stage and the queue.
module notation_field_tokenizer #(
	parameter int FIELD_COLS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // field_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] kind, [7:4] start_col, [11:8] elem_len,
	                               // [15:12] elem_number, [17:16] error_code, zeros above
	output logic        m_tlast    // field_end
);

	logic              valid_s1;
	logic [7:0]        ch_s1;
	logic              last_s1;
	logic              room;
	logic              consume;
	nft_pkg::res_vec_t res;
	logic [1:0]        res_n;
	nft_pkg::res_t     head;

	assign consume  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	nft_parser #(
		.FIELD_COLS(FIELD_COLS)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (consume),
		.ch    (ch_s1),
		.last  (last_s1),
		.res   (res),
		.res_n (res_n)
	);

	nft_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (consume),
		.push_res  (res),
		.push_n    (res_n),
		.room      (room),
		.head_valid(m_tvalid),
		.head      (head),
		.pop       (m_tready)
	);

	assign m_tdata = {6'd0, head.error_code, head.elem_number, head.elem_len,
		head.start_col, head.kind};
	assign m_tlast = head.field_end;

endmodule
